// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants and types for the sorted key table: table geometry,
// operation and status codes, the stored entry and the RAM write port.
// ----------------------------------------------------------------------------
package skt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = 7;
   localparam int WORD_W      = 32;

   // Operation codes on req_kind.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_FIND   = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   // Status codes on rsp_status.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_HANDLER = 3'd1;
   localparam logic [2:0] ST_ZERO_KEY   = 3'd2;
   localparam logic [2:0] ST_DUPLICATE  = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;

   // One stored entry.
   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] payload;
      logic [WORD_W-1:0] order;
   } entry_type;

   // Write port of the entry RAM.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } ram_write_type;

endpackage

// ----- hdl/sorted_key_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Rejected inserts and trivial misses are answered from idle, a read hit after
// its RAM read; a find runs s binary search steps (s <= 7 at 64 entries) and
// checks the lower-bound entry; an insert also moves the m entries above that
// position up one place, then writes the new entry. One operation at a time;
// a new start can be taken in the cycle its result is strobed, and the
// receiver cannot stall results. The entry RAM allows one read per cycle,
// which sets the search and shift times. Synchronous reset empties the table
// and zeroes the sequence number; the entry RAM itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_key,
   input  logic [31:0] req_payload,
   input  logic        req_has_handler,
   input  logic [6:0]  req_index,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_found,
   output logic [6:0]  rsp_position,
   output logic [31:0] rsp_entry_key,
   output logic [31:0] rsp_entry_payload,
   output logic [31:0] rsp_entry_order,
   output logic [6:0]  rsp_entry_count
);

   localparam int AW = skt_pkg::ADDR_W;
   localparam int CW = skt_pkg::CNT_W;
   localparam int WW = skt_pkg::WORD_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE        = 3'd0;
   localparam logic [2:0] S_SEARCH      = 3'd1;
   localparam logic [2:0] S_SEARCH_WAIT = 3'd2;
   localparam logic [2:0] S_CHECK_WAIT  = 3'd3;
   localparam logic [2:0] S_READ_WAIT   = 3'd4;
   localparam logic [2:0] S_SHIFT       = 3'd5;

   typedef struct packed {
      logic [2:0]    status;
      logic          found;
      logic [CW-1:0] position;
      logic [WW-1:0] key;
      logic [WW-1:0] payload;
      logic [WW-1:0] order;
      logic [CW-1:0] count;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [2:0] status, input logic found,
                                        input logic [CW-1:0] position,
                                        input skt_pkg::entry_type ent,
                                        input logic [CW-1:0] count);
      rsp_type r;
      r.status   = status;
      r.found    = found;
      r.position = position;
      r.key      = ent.key;
      r.payload  = ent.payload;
      r.order    = ent.order;
      r.count    = count;
      return r;
   endfunction

   // Control state.
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [WW-1:0] next_order_ff, next_order_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pend_ff, pend_in;

   // Operation context and search bounds.
   logic [1:0]    kind_ff, kind_in;
   logic [WW-1:0] key_ff, key_in;
   logic [WW-1:0] payload_ff, payload_in;
   logic [WW-1:0] order_ff, order_in;
   logic [CW-1:0] index_ff, index_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic          probe_ff, probe_in;
   logic [AW-1:0] shift_ff, shift_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   rsp_type       rsp_ff, rsp_in;

   // RAM ports.
   skt_pkg::ram_write_type wr;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   skt_pkg::entry_type     rd_data;

   logic [CW:0]            mid_sum;
   logic [CW-1:0]          mid_full;
   logic                   hit;
   skt_pkg::entry_type     zero_entry;
   skt_pkg::entry_type     new_entry;

   skt_entry_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_full   = mid_sum[CW:1];
   assign hit        = probe_ff && (rd_data.key == key_ff);
   assign zero_entry = '0;
   assign new_entry  = '{key: key_ff, payload: payload_ff, order: order_ff};

   // Sequencer: search, check, shift and result formation.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_order_in = next_order_ff;
      rsp_valid_in  = 1'b0;
      pend_in       = pend_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      payload_in    = payload_ff;
      order_in      = order_ff;
      index_in      = index_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      probe_in      = probe_ff;
      shift_in      = shift_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_in        = rsp_ff;
      wr            = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in    = req_kind;
               key_in     = req_key;
               payload_in = req_payload;
               lo_in      = '0;
               hi_in      = count_ff;
               case (req_kind)
                  skt_pkg::KIND_INSERT: begin
                     if (!req_has_handler) begin
                        rsp_in = make_rsp(skt_pkg::ST_NO_HANDLER, 1'b0, '0, zero_entry,
                                          count_ff);
                        rsp_valid_in = 1'b1;
                     end else if (req_key == '0) begin
                        rsp_in = make_rsp(skt_pkg::ST_ZERO_KEY, 1'b0, '0, zero_entry,
                                          count_ff);
                        rsp_valid_in = 1'b1;
                     end else begin
                        order_in      = next_order_ff;
                        next_order_in = next_order_ff + WW'(1);
                        state_in      = S_SEARCH;
                     end
                  end
                  skt_pkg::KIND_FIND: begin
                     if (req_key != '0 && count_ff != '0) begin
                        state_in = S_SEARCH;
                     end else begin
                        rsp_in = make_rsp(skt_pkg::ST_OK, 1'b0, '0, zero_entry, count_ff);
                        rsp_valid_in = 1'b1;
                     end
                  end
                  skt_pkg::KIND_READ: begin
                     if (req_index < count_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_index[AW-1:0];
                        index_in = req_index;
                        state_in = S_READ_WAIT;
                     end else begin
                        rsp_in = make_rsp(skt_pkg::ST_OK, 1'b0, '0, zero_entry, count_ff);
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in = make_rsp(skt_pkg::ST_OK, 1'b0, '0, zero_entry, count_ff);
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // One binary search step: probe the midpoint, or finish and
         // probe the lower-bound position if it lies inside the table.
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_full[AW-1:0];
               rd_en    = 1'b1;
               rd_addr  = mid_full[AW-1:0];
               state_in = S_SEARCH_WAIT;
            end else begin
               probe_in = (lo_ff < count_ff);
               rd_en    = (lo_ff < count_ff);
               rd_addr  = lo_ff[AW-1:0];
               state_in = S_CHECK_WAIT;
            end
         end

         S_SEARCH_WAIT: begin
            if (rd_data.key < key_ff) begin
               lo_in = {1'b0, mid_ff} + CW'(1);
            end else begin
               hi_in = {1'b0, mid_ff};
            end
            state_in = S_SEARCH;
         end

         // Lower bound known: answer a find, or decide the insert.
         S_CHECK_WAIT: begin
            if (kind_ff == skt_pkg::KIND_FIND) begin
               if (hit) begin
                  rsp_in = make_rsp(skt_pkg::ST_OK, 1'b1, lo_ff, rd_data, count_ff);
               end else begin
                  rsp_in = make_rsp(skt_pkg::ST_OK, 1'b0, '0, zero_entry, count_ff);
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (hit) begin
               rsp_in = make_rsp(skt_pkg::ST_DUPLICATE, 1'b0, lo_ff, zero_entry, count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (count_ff >= CW'(skt_pkg::TABLE_DEPTH)) begin
               rsp_in = make_rsp(skt_pkg::ST_FULL, 1'b0, lo_ff, zero_entry, count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               shift_in = count_ff[AW-1:0];
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end
         end

         // Move entries up one place, top first: read i-1 while the entry
         // read in the previous cycle is written to its new place. Then
         // write the new entry at the lower-bound position.
         S_SHIFT: begin
            if (pend_ff) begin
               wr.en   = 1'b1;
               wr.addr = pend_addr_ff;
               wr.data = rd_data;
            end
            if (shift_ff > lo_ff[AW-1:0]) begin
               rd_en        = 1'b1;
               rd_addr      = shift_ff - AW'(1);
               pend_in      = 1'b1;
               pend_addr_in = shift_ff;
               shift_in     = shift_ff - AW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  wr.en    = 1'b1;
                  wr.addr  = lo_ff[AW-1:0];
                  wr.data  = new_entry;
                  count_in = count_ff + CW'(1);
                  rsp_in   = make_rsp(skt_pkg::ST_OK, 1'b0, lo_ff, new_entry,
                                      count_ff + CW'(1));
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end

         S_READ_WAIT: begin
            rsp_in = make_rsp(skt_pkg::ST_OK, 1'b1, index_ff, rd_data, count_ff);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_order_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_order_ff <= next_order_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      payload_ff   <= payload_in;
      order_ff     <= order_in;
      index_ff     <= index_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      probe_ff     <= probe_in;
      shift_ff     <= shift_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   // Outputs.
   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_found         = rsp_ff.found;
   assign rsp_position      = rsp_ff.position;
   assign rsp_entry_key     = rsp_ff.key;
   assign rsp_entry_payload = rsp_ff.payload;
   assign rsp_entry_order   = rsp_ff.order;
   assign rsp_entry_count   = rsp_ff.count;

`ifndef NO_ASSERTIONS
   // A result is only issued once the sequencer is back at rest.
   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result issued while busy");

   // The entry count never exceeds the table depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(skt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // A located entry always comes with an ok status.
   a_found_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (rsp_status == skt_pkg::ST_OK))
      else $error("found with non-ok status");

   // During the shift, the write and the read never touch the same entry.
   a_shift_no_overlap : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && wr.en && rd_en) |-> (wr.addr != rd_addr))
      else $error("shift read and write collide");

   // The count only grows through a successful insert result.
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && count_in != count_ff) |=> (rsp_strobe && rsp_status ==
         skt_pkg::ST_OK))
      else $error("count changed without insert result");
`endif

endmodule

// ----- hdl/skt_entry_ram.sv -----
// ----------------------------------------------------------------------------
// skt_entry_ram
// Entry storage: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module skt_entry_ram (
   input  logic                          clock,
   input  skt_pkg::ram_write_type        wr,
   input  logic                          rd_en,
   input  logic [skt_pkg::ADDR_W-1:0]    rd_addr,
   output skt_pkg::entry_type            rd_data
);

   skt_pkg::entry_type mem [0:skt_pkg::TABLE_DEPTH-1];
   skt_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port; the data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
